FILE: src/gdfr_pkg.sv
`timescale 1ns / 1ps

package gdfr_pkg;

  // Grid geometry
  localparam int GridSize = 64;
  localparam int SeedRows = 2;
  localparam int NbCount  = 8;
  localparam int Cells    = GridSize * GridSize;
  localparam int AddrW    = $clog2(Cells);
  localparam int NbIdxW   = $clog2(NbCount);

  // Field widths
  localparam int CoordW = 6;
  localparam int ScoreW = 8;
  localparam int TerrW  = 8;
  localparam int ActW   = 2;

  // Action codes
  localparam logic [ActW-1:0] ActWrite = 2'd0;
  localparam logic [ActW-1:0] ActRelax = 2'd1;
  localparam logic [ActW-1:0] ActRead  = 2'd2;

  localparam logic [TerrW-1:0]  EntranceReset = 8'h18;
  localparam logic [ScoreW-1:0] ScoreEntrance = 8'hff;
  localparam logic [ScoreW-1:0] ScoreEdge     = 8'hfe;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [TerrW-1:0]  terrain_value;
  } in_word_t;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [ScoreW-1:0] score;
  } out_word_t;

  // Flat memory index of cell (x, y)
  function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW-1:0] x,
                                                 input logic [CoordW-1:0] y);
    int idx;
    idx = int'(x) * GridSize + int'(y);
    return idx[AddrW-1:0];
  endfunction

  // 8-connected neighbor offsets
  function automatic logic signed [1:0] nb_dx(input logic [NbIdxW-1:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [NbIdxW-1:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

FILE: src/gdfr_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module gdfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/grid_distance_field_relax.sv
`timescale 1ns / 1ps

// Distance-field relaxation over a 64x64 grid, terrain and score kept in two RAMs.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one command word:
//   write terrain - stores the byte, no result, block free again the next cycle
//   relax score   - updates one score cell and returns the new score
//   read score    - returns the stored score of the cell
// Action code 3 and off-grid coordinates are dropped without a result.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns a word of
// cell coordinates plus score. One output register decouples the two sides.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) loads entrance_code;
// it is always ready and must be written only while the block is idle.
//
// A write completes in the idle state; a read or seed-row relax passes through its
// own state (S_READ or S_SEED). The interior relax walks the eight neighbors one per
// cycle through the single score read port, then writes back in S_FINISH.
// If the output register is still held by out_stall_i the result parks in a
// holding register and in_stall_o stays high.
// After reset both RAMs are zeroed by a clearing pass, one cell per cycle, with
// in_stall_o high throughout; config writes are taken as usual.
module grid_distance_field_relax (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gdfr_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdfr_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import gdfr_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SEED   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [TerrW-1:0]  entrance_q;
  in_word_t          item_q, item_d;
  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [NbIdxW-1:0] nb_q, nb_d;
  logic              rd_vld_q, rd_vld_d;
  logic [ScoreW-1:0] best_q, best_d;
  logic [ScoreW-1:0] res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  // RAM ports
  logic              terr_we, score_we;
  logic [AddrW-1:0]  terr_waddr, terr_raddr, score_waddr, score_raddr;
  logic [TerrW-1:0]  terr_wdata, terr_rdata;
  logic [ScoreW-1:0] score_wdata, score_rdata;

  logic              in_acc, in_on_grid, out_free, load_out;
  logic [ScoreW-1:0] cand, relax_v, res_val;
  logic [AddrW-1:0]  in_addr, item_addr, nb_addr;
  logic signed [CoordW+1:0] nx_s, ny_s;
  logic              nb_in;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_on_grid  = (int'(in_data_i.cell_x) < GridSize) &&
                       (int'(in_data_i.cell_y) < GridSize);
  assign in_addr     = cell_addr(in_data_i.cell_x, in_data_i.cell_y);
  assign item_addr   = cell_addr(item_q.cell_x, item_q.cell_y);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Neighbor under scan; off-grid neighbors still take their scan step
  assign nx_s    = $signed({2'b00, item_q.cell_x}) + (CoordW+2)'(nb_dx(nb_q));
  assign ny_s    = $signed({2'b00, item_q.cell_y}) + (CoordW+2)'(nb_dy(nb_q));
  assign nb_in   = (nx_s >= 0) && (nx_s <= GridSize - 1) &&
                   (ny_s >= 0) && (ny_s <= GridSize - 1);
  assign nb_addr = cell_addr(nx_s[CoordW-1:0], ny_s[CoordW-1:0]);

  // Running max folds in the read issued in the previous cycle
  assign cand    = (rd_vld_q && (score_rdata > best_q)) ? score_rdata : best_q;
  assign relax_v = (cand == '0) ? '0 : cand - ScoreW'(1);

  always_comb begin
    terr_we     = 1'b0;
    terr_waddr  = in_addr;
    terr_wdata  = in_data_i.terrain_value;
    terr_raddr  = in_addr;
    score_we    = 1'b0;
    score_waddr = item_addr;
    score_wdata = relax_v;
    score_raddr = (state_q == S_SCAN) ? nb_addr : in_addr;
    res_val     = relax_v;

    case (state_q)
      S_CLEAR: begin
        terr_we     = 1'b1;
        terr_waddr  = clr_cnt_q;
        terr_wdata  = '0;
        score_we    = 1'b1;
        score_waddr = clr_cnt_q;
        score_wdata = '0;
      end
      S_IDLE: begin
        terr_we = in_acc && in_on_grid && (in_data_i.action == ActWrite);
      end
      S_SEED: begin
        res_val     = (terr_rdata == entrance_q) ? ScoreEntrance : ScoreEdge;
        score_we    = 1'b1;
        score_wdata = res_val;
      end
      S_READ: begin
        res_val = score_rdata;
      end
      S_FINISH: begin
        score_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    clr_cnt_d   = clr_cnt_q;
    nb_d        = nb_q;
    rd_vld_d    = 1'b0;
    best_d      = best_q;
    res_d       = res_q;
    load_out    = 1'b0;
    out_d       = out_q;

    case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(Cells - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          item_d = in_data_i;
          nb_d   = '0;
          best_d = '0;
          if (in_on_grid && (in_data_i.action == ActRead)) begin
            state_d = S_READ;
          end else if (in_on_grid && (in_data_i.action == ActRelax)) begin
            if (int'(in_data_i.cell_y) < SeedRows) begin
              state_d = S_SEED;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        best_d   = cand;
        rd_vld_d = nb_in;
        nb_d     = nb_q + NbIdxW'(1);
        if (nb_q == NbIdxW'(NbCount - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_SEED, S_READ, S_FINISH: begin
        res_d = res_val;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_out) begin
      out_d.out_x = item_q.cell_x;
      out_d.out_y = item_q.cell_y;
      out_d.score = (state_q == S_EMIT) ? res_q : res_val;
    end
    out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      nb_q        <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      entrance_q  <= EntranceReset;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      nb_q        <= nb_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        entrance_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    best_q <= best_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  gdfr_ram #(
    .Width(TerrW),
    .Depth(Cells)
  ) u_terrain_ram (
    .clk_i  (clk_i),
    .we_i   (terr_we),
    .waddr_i(terr_waddr),
    .wdata_i(terr_wdata),
    .raddr_i(terr_raddr),
    .rdata_o(terr_rdata)
  );

  gdfr_ram #(
    .Width(ScoreW),
    .Depth(Cells)
  ) u_score_ram (
    .clk_i  (clk_i),
    .we_i   (score_we),
    .waddr_i(score_waddr),
    .wdata_i(score_wdata),
    .raddr_i(score_raddr),
    .rdata_o(score_rdata)
  );

  // Score RAM is never written while waiting for a new word
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !score_we)
    else $error("score write while idle");

  // Output register only reloads once its word has left
  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(out_valid_q && out_stall_i))
    else $error("output word overwritten");

  // A pending neighbor read only exists inside the scan
  a_rd_vld_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ((state_q == S_SCAN) || (state_q == S_FINISH)))
    else $error("stray neighbor read");

  // Interior relax runs its full eight-step scan
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && (nb_q != NbIdxW'(NbCount - 1))) |=> (state_q == S_SCAN))
    else $error("scan cut short");

  // Results only appear as the end of a relax or read
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_SEED || $past(state_q) == S_READ ||
                            $past(state_q) == S_FINISH || $past(state_q) == S_EMIT))
    else $error("result without item");

endmodule

FILE: dv/grid_distance_field_relax_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the distance-field relax block.
// The driver pops command words from a queue, and the monitor checks result words against
// a queue of predicted scores.
module grid_distance_field_relax_tb;
  import gdfr_pkg::*;

  // The block has no use for action code 3: it is dropped silently.
  localparam logic [ActW-1:0] ActUnused = 2'd3;

  // The longest legal quiet stretch is the clearing pass after reset,
  // so the watchdog limit sits well above it.
  localparam int WatchdogLimit = 20000;
  // Slowest word is an interior relax plus the output register.
  localparam int SettleCycles  = 16;
  localparam int PhaseWords    = 450;
  localparam int PrintLimit    = 100;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [TerrW-1:0] cfg_data = '0;

  // Shadow copy of both grids and the entrance register.
  logic [TerrW-1:0]  terrain_mem [Cells];
  logic [ScoreW-1:0] score_mem [Cells];
  logic [TerrW-1:0]  entrance_code = EntranceReset;

  in_word_t  cmd_fifo [$];        // words waiting to be driven
  out_word_t pending_scores [$];  // predicted results, oldest first
  int        err_count = 0;

  grid_distance_field_relax uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int grid_idx(input int x, input int y);
    return x * GridSize + y;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PrintLimit) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Update the shadow grids for one accepted word. Queue the result it should produce.
  task automatic apply_grid_cmd(input in_word_t w);
    int nx, ny;
    logic [ScoreW-1:0] best, val;
    out_word_t r;
    best = '0;
    val  = '0;
    r.out_x = w.cell_x;
    r.out_y = w.cell_y;
    case (w.action)
      ActWrite: begin
        terrain_mem[grid_idx(w.cell_x, w.cell_y)] = w.terrain_value;
      end
      ActRelax: begin
        if (w.cell_y < SeedRows) begin
          // seed row: the terrain byte alone decides
          val = (terrain_mem[grid_idx(w.cell_x, w.cell_y)] == entrance_code) ?
                ScoreEntrance : ScoreEdge;
        end else begin
          // max over the 8-connected ring, off-grid neighbors skipped
          for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
              nx = int'(w.cell_x) + dx;
              ny = int'(w.cell_y) + dy;
              if ((dx != 0 || dy != 0) && nx >= 0 && nx < GridSize &&
                  ny >= 0 && ny < GridSize && score_mem[grid_idx(nx, ny)] > best)
                best = score_mem[grid_idx(nx, ny)];
            end
          end
          val = (best == '0) ? '0 : best - 1'b1;
        end
        score_mem[grid_idx(w.cell_x, w.cell_y)] = val;
        r.score = val;
        pending_scores.push_back(r);
      end
      ActRead: begin
        r.score = score_mem[grid_idx(w.cell_x, w.cell_y)];
        pending_scores.push_back(r);
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  // Driver: random bursts separated by random gaps. A stalled word is held unchanged.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_grid_cmd(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_fifo.size() > 0) begin
          in_data  <= cmd_fifo.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each word taken from the output against the oldest prediction.
  // Stall runs are kept short, with an occasional long run and some long open
  // stretches.
  int stall_left = 0;

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_scores.size() == 0) begin
          report_mismatch($sformatf("unexpected word x=%0d y=%0d score=%0d",
                                    out_data.out_x, out_data.out_y, out_data.score));
        end else begin
          want = pending_scores.pop_front();
          if (out_data.out_x !== want.out_x)
            report_mismatch($sformatf("out_x %0d, want %0d", out_data.out_x, want.out_x));
          if (out_data.out_y !== want.out_y)
            report_mismatch($sformatf("out_y %0d, want %0d", out_data.out_y, want.out_y));
          if (out_data.score !== want.score)
            report_mismatch($sformatf("score %0d at (%0d,%0d), want %0d", out_data.score,
                                      want.out_x, want.out_y, want.score));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (out_stall) begin
        out_stall  <= 1'b0;
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) :
                                                   $urandom_range(0, 12);
      end else begin
        out_stall  <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) :
                                                   $urandom_range(0, 8);
      end
    end
  end

  // Watchdog: abort if no word moves on any channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [ActW-1:0] act, input int x, input int y,
                           input int tv);
    in_word_t w;
    w.action        = act;
    w.cell_x        = x[CoordW-1:0];
    w.cell_y        = y[CoordW-1:0];
    w.terrain_value = tv[TerrW-1:0];
    cmd_fifo.push_back(w);
  endtask

  // Block until the input queue is empty and every predicted result has arrived,
  // then let a possible trailing terrain write finish. Checked on the falling
  // edge, when all of the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_fifo.size() != 0 || in_valid || pending_scores.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_entrance(input logic [TerrW-1:0] code);
    @(posedge clk_i);
    cfg_data  <= code;
    cfg_valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    entrance_code = code;
  endtask

  // Directed opening: seed rows, all four grid edges, the corners, the unused code
  // and reads before and after.
  task automatic directed_words();
    push_word(ActRead,  0, 0, 8'h00);              // cleared at reset
    push_word(ActRelax, 5, 40, 8'hff);             // interior, all neighbors zero
    push_word(ActWrite, 0, 0, EntranceReset);
    push_word(ActRelax, 0, 0, 8'h00);              // entrance on seed row
    push_word(ActRelax, 0, 1, 8'hff);              // plain seed cell
    push_word(ActWrite, 63, 1, 8'hff);
    push_word(ActRelax, 63, 1, 8'h00);
    push_word(ActWrite, 63, 0, EntranceReset ^ 8'h01);  // one bit off the code
    push_word(ActRelax, 63, 0, 8'h00);
    push_word(ActRelax, 0, 2, 8'h00);              // left edge, ring clipped
    push_word(ActRelax, 63, 2, 8'h00);             // right edge
    push_word(ActRelax, 62, 2, 8'h00);
    push_word(ActRelax, 1, 2, 8'h00);
    push_word(ActRelax, 63, 63, 8'h00);            // corner: five neighbors off grid
    push_word(ActRelax, 0, 63, 8'h00);
    push_word(ActRead,  0, 0, 8'h00);
    push_word(ActRead,  63, 2, 8'h00);
    push_word(ActUnused, 63, 63, 8'hff);           // dropped, grids untouched
    push_word(ActRead,  63, 63, 8'h00);
    push_word(ActWrite, 63, 63, 8'hff);            // terrain only, score unchanged
    push_word(ActRead,  63, 63, 8'h00);
    push_word(ActRelax, 1, 3, 8'h00);
  endtask

  // Random part. Mostly gradient strips: seed the two bottom rows of a few
  // columns, then relax row by row upward so scores spread into the interior.
  // The rest is raw noise over the whole command space.
  task automatic random_words(input int target);
    int count, x0, width, depth, a;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          a = $urandom_range(0, 3);
          push_word(ActW'(a), $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 255));
          if (a != ActUnused) count++;
        end
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          width = 1;                     // rare full-height column
          depth = GridSize - 1;
        end else begin
          width = $urandom_range(1, 6);
          depth = $urandom_range(2, 12);
        end
        x0 = $urandom_range(0, GridSize - width);
        for (int x = x0; x < x0 + width; x++) begin
          if ($urandom_range(0, 1)) begin
            push_word(ActWrite, x, $urandom_range(0, 1),
                      $urandom_range(0, 1) ? int'(entrance_code) : $urandom_range(0, 255));
            count++;
          end
          push_word(ActRelax, x, 0, $urandom_range(0, 255));
          push_word(ActRelax, x, 1, $urandom_range(0, 255));
          count += 2;
        end
        for (int y = 2; y <= depth; y++) begin
          for (int x = x0; x < x0 + width; x++) begin
            push_word(ActRelax, x, y, $urandom_range(0, 255));
            count++;
          end
          if ($urandom_range(0, 3) == 0) begin
            push_word(ActRead, $urandom_range(x0, x0 + width - 1), $urandom_range(0, y),
                      $urandom_range(0, 255));
            count++;
          end
        end
      end
    end
  endtask

  initial begin
    logic [TerrW-1:0] phase_codes [4];
    phase_codes[0] = 8'h00;
    phase_codes[1] = 8'hff;
    phase_codes[2] = TerrW'($urandom_range(1, 254));
    phase_codes[3] = TerrW'($urandom_range(0, 255));
    for (int i = 0; i < Cells; i++) begin
      terrain_mem[i] = '0;
      score_mem[i]   = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first phase runs with the reset entrance code. Each later phase reloads it
    // once the block has gone idle.
    directed_words();
    wait_idle();
    foreach (phase_codes[i]) begin
      write_entrance(phase_codes[i]);
      random_words(PhaseWords);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
